// File: rtl/core/dnsle_pkg.sv
// ----------------------------------------------------------------------------
// dnsle_pkg : shared types and constants for the DNS name label encoder
// Field widths, status codes and the command word that passes from the
// front part to the back part through the command queue.
// ----------------------------------------------------------------------------
package dnsle_pkg;

  localparam int CH_W   = 8;
  localparam int MOFF_W = 9;
  localparam int OFF_W  = 10;
  localparam int Q_W    = 16;
  localparam int ST_W   = 3;
  localparam int LEN_W  = 8;
  // wide enough to compare a sum against a message limit up to 2047
  localparam int SUM_W  = 11;

  localparam logic [CH_W-1:0]  DOT_CHAR = 8'h2E;
  localparam logic [LEN_W-1:0] LEN_SAT  = 8'hFF;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 3'd0,
    ST_LIMIT      = 3'd1,
    ST_NAME_LONG  = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_LABEL_LONG = 3'd4
  } status_t;

  // what follows the optional byte write of one character
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_ERR,
    TAIL_OK
  } tail_t;

  // back part step numbers
  localparam logic [2:0] STEP_CHAR  = 3'd0;
  localparam logic [2:0] STEP_LABEL = 3'd1;
  localparam logic [2:0] STEP_TERM  = 3'd2;
  localparam logic [2:0] STEP_TH    = 3'd3;
  localparam logic [2:0] STEP_TL    = 3'd4;
  localparam logic [2:0] STEP_CH    = 3'd5;
  localparam logic [2:0] STEP_CL    = 3'd6;

  typedef struct packed {
    logic              has_wr;
    logic [OFF_W-1:0]  wr_off;
    logic [CH_W-1:0]   wr_byte;
    tail_t             tail;
    status_t           err;
    logic [OFF_W-1:0]  label_off;
    logic [LEN_W-1:0]  label_len;
    logic [OFF_W-1:0]  tail_base;
    logic [Q_W-1:0]    query_type;
    logic [Q_W-1:0]    query_class;
  } cmd_t;

endpackage

// File: rtl/core/dnsle_if.sv
// ----------------------------------------------------------------------------
// dnsle_if : valid/ready channels of the DNS name label encoder
// Input channel carries one name character per word, output channel one
// addressed byte write or a status word.
// ----------------------------------------------------------------------------
interface dnsle_in_if;
  import dnsle_pkg::*;

  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   ch;
  logic              end_of_name;
  logic [MOFF_W-1:0] msg_offset;
  logic [Q_W-1:0]    query_type;
  logic [Q_W-1:0]    query_class;

  modport source (output valid, ch, end_of_name, msg_offset, query_type, query_class,
                  input ready);
  modport sink (input valid, ch, end_of_name, msg_offset, query_type, query_class,
                output ready);
endinterface

interface dnsle_out_if;
  import dnsle_pkg::*;

  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] wr_offset;
  logic [CH_W-1:0]  wr_byte;
  logic             wr_valid;
  logic             last;
  logic [ST_W-1:0]  status;
  logic [OFF_W-1:0] new_size;

  modport source (output valid, wr_offset, wr_byte, wr_valid, last, status, new_size,
                  input ready);
  modport sink (input valid, wr_offset, wr_byte, wr_valid, last, status, new_size,
                output ready);
endinterface

// File: rtl/core/dnsle_front.sv
// ----------------------------------------------------------------------------
// dnsle_front : character classifier and name state
// Tracks position, label start and length, runs the limit and label checks,
// and makes one command word per accepted byte write or end of name.
// ----------------------------------------------------------------------------
module dnsle_front #(
  parameter int MAX_LABEL = 63,
  parameter int MAX_NAME  = 255,
  parameter int MSG_LIMIT = 512
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [7:0]     ch,
  input  logic           end_of_name,
  input  logic [8:0]     msg_offset,
  input  logic [15:0]    query_type,
  input  logic [15:0]    query_class,
  output logic           push,
  output dnsle_pkg::cmd_t cmd
);
  import dnsle_pkg::*;

  localparam int NPW = $clog2(MAX_NAME + 2);

  logic [OFF_W-1:0] base_offset, base_offset_next;
  logic [NPW-1:0]   name_pos, name_pos_next;
  logic [NPW-1:0]   label_start, label_start_next;
  logic [LEN_W-1:0] label_len, label_len_next;
  status_t          err_code, err_code_next;
  logic             in_name;

  logic [OFF_W-1:0] cur_base;
  logic [NPW-1:0]   cur_pos, cur_ls;
  logic [LEN_W-1:0] cur_len;
  status_t          cur_err;
  logic [SUM_W-1:0] pos_sum;
  logic [OFF_W-1:0] end_base;

  // classify the character against the name state
  always_comb begin
    cur_base = in_name ? base_offset : OFF_W'(msg_offset);
    cur_pos  = in_name ? name_pos : NPW'(1);
    cur_ls   = in_name ? label_start : '0;
    cur_len  = in_name ? label_len : '0;
    cur_err  = in_name ? err_code : ST_OK;
    pos_sum  = SUM_W'(cur_base) + SUM_W'(cur_pos);

    base_offset_next = cur_base;
    name_pos_next    = cur_pos;
    label_start_next = cur_ls;
    label_len_next   = cur_len;
    err_code_next    = cur_err;

    cmd          = '0;
    cmd.tail     = TAIL_NONE;
    cmd.err      = ST_OK;
    cmd.query_type  = query_type;
    cmd.query_class = query_class;

    if (cur_err == ST_OK) begin
      if (pos_sum >= SUM_W'(MSG_LIMIT)) begin
        err_code_next = ST_LIMIT;
      end else if (cur_pos > NPW'(MAX_NAME)) begin
        err_code_next = ST_NAME_LONG;
      end else if (ch != DOT_CHAR) begin
        if (cur_len != LEN_SAT) label_len_next = cur_len + 1'b1;
        cmd.has_wr    = 1'b1;
        cmd.wr_off    = pos_sum[OFF_W-1:0];
        cmd.wr_byte   = ch;
        name_pos_next = cur_pos + 1'b1;
      end else if (cur_len == '0) begin
        err_code_next = ST_EMPTY;
      end else if (cur_len > LEN_W'(MAX_LABEL)) begin
        err_code_next = ST_LABEL_LONG;
      end else begin
        // dot: length byte goes back to the label start
        cmd.has_wr       = 1'b1;
        cmd.wr_off       = cur_base + OFF_W'(cur_ls);
        cmd.wr_byte      = cur_len;
        label_start_next = cur_pos;
        name_pos_next    = cur_pos + 1'b1;
        label_len_next   = '0;
      end
    end

    // end of name: last label check and trailer
    end_base = base_offset_next + OFF_W'(name_pos_next);
    if (end_of_name) begin
      if (err_code_next == ST_OK) begin
        if (label_len_next == '0) err_code_next = ST_EMPTY;
        else if (label_len_next > LEN_W'(MAX_LABEL)) err_code_next = ST_LABEL_LONG;
      end
      cmd.tail      = (err_code_next == ST_OK) ? TAIL_OK : TAIL_ERR;
      cmd.err       = err_code_next;
      cmd.label_off = base_offset_next + OFF_W'(label_start_next);
      cmd.label_len = label_len_next;
      cmd.tail_base = end_base;
    end
  end

  assign push = take && (cmd.has_wr || end_of_name);

  // name state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_offset <= '0;
      name_pos    <= NPW'(1);
      label_start <= '0;
      label_len   <= '0;
      err_code    <= ST_OK;
      in_name     <= 1'b0;
    end else if (take) begin
      if (end_of_name) begin
        in_name     <= 1'b0;
        name_pos    <= NPW'(1);
        label_start <= '0;
        label_len   <= '0;
        err_code    <= ST_OK;
      end else begin
        in_name     <= 1'b1;
        base_offset <= base_offset_next;
        name_pos    <= name_pos_next;
        label_start <= label_start_next;
        label_len   <= label_len_next;
        err_code    <= err_code_next;
      end
    end
  end

endmodule

// File: rtl/core/dnsle_queue.sv
// ----------------------------------------------------------------------------
// dnsle_queue : short command queue
// Register FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module dnsle_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dnsle_pkg::cmd_t push_cmd,
  input  logic            pop,
  output dnsle_pkg::cmd_t head,
  output logic            full,
  output logic            empty
);
  import dnsle_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

endmodule

// File: rtl/core/dnsle_back.sv
// ----------------------------------------------------------------------------
// dnsle_back : result sequencer
// Expands the head command into one to seven output words, one per cycle while
// the output is accepted, into a registered output stage.
// ----------------------------------------------------------------------------
module dnsle_back (
  input  logic            clk,
  input  logic            rst,
  input  dnsle_pkg::cmd_t head,
  input  logic            empty,
  output logic            pop,
  dnsle_out_if.source     out_ch
);
  import dnsle_pkg::*;

  logic [2:0]       step;
  logic [2:0]       cur_step;
  logic [2:0]       final_step;
  logic             load;
  logic             out_valid;
  logic [OFF_W-1:0] r_off;
  logic [CH_W-1:0]  r_byte;
  logic             r_wr, r_last;
  status_t          r_status;
  logic [OFF_W-1:0] r_size;
  logic [OFF_W-1:0] o_off;
  logic [CH_W-1:0]  o_byte;
  logic             o_wr, o_last;
  status_t          o_status;
  logic [OFF_W-1:0] o_size;

  assign load = !out_valid || out_ch.ready;

  // pick the word for the current step
  always_comb begin
    cur_step = (step == STEP_CHAR && !head.has_wr) ? STEP_LABEL : step;
    case (head.tail)
      TAIL_OK:  final_step = STEP_CL;
      TAIL_ERR: final_step = STEP_LABEL;
      default:  final_step = STEP_CHAR;
    endcase

    r_off    = '0;
    r_byte   = '0;
    r_wr     = 1'b1;
    r_last   = 1'b0;
    r_status = ST_OK;
    r_size   = '0;
    case (cur_step)
      STEP_CHAR: begin
        r_off  = head.wr_off;
        r_byte = head.wr_byte;
      end
      STEP_LABEL: begin
        if (head.tail == TAIL_ERR) begin
          r_wr     = 1'b0;
          r_last   = 1'b1;
          r_status = head.err;
        end else begin
          r_off  = head.label_off;
          r_byte = head.label_len;
        end
      end
      STEP_TERM: r_off = head.tail_base;
      STEP_TH: begin
        r_off  = head.tail_base + OFF_W'(1);
        r_byte = head.query_type[15:8];
      end
      STEP_TL: begin
        r_off  = head.tail_base + OFF_W'(2);
        r_byte = head.query_type[7:0];
      end
      STEP_CH: begin
        r_off  = head.tail_base + OFF_W'(3);
        r_byte = head.query_class[15:8];
      end
      STEP_CL: begin
        r_off  = head.tail_base + OFF_W'(4);
        r_byte = head.query_class[7:0];
        r_last = 1'b1;
        r_size = head.tail_base + OFF_W'(5);
      end
      default: r_wr = 1'b0;
    endcase
  end

  assign pop = load && !empty && (cur_step == final_step);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_CHAR;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) step <= (cur_step == final_step) ? STEP_CHAR : cur_step + 1'b1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (load && !empty) begin
      o_off    <= r_off;
      o_byte   <= r_byte;
      o_wr     <= r_wr;
      o_last   <= r_last;
      o_status <= r_status;
      o_size   <= r_size;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.wr_offset = o_off;
  assign out_ch.wr_byte   = o_byte;
  assign out_ch.wr_valid  = o_wr;
  assign out_ch.last      = o_last;
  assign out_ch.status    = o_status;
  assign out_ch.new_size  = o_size;

`ifndef SYNTHESIS
  a_step_range : assert property (@(posedge clk) disable iff (rst)
    step <= STEP_CL) else $error("step counter out of range");
  a_mid_cmd : assert property (@(posedge clk) disable iff (rst)
    step != STEP_CHAR |-> !empty) else $error("step running with no command");
  a_err_nowrite : assert property (@(posedge clk) disable iff (rst)
    out_valid && o_last && o_status != ST_OK |-> !o_wr)
    else $error("error word carries a write");
  a_ok_size : assert property (@(posedge clk) disable iff (rst)
    out_valid && o_last && o_status == ST_OK |-> o_wr && o_size == o_off + OFF_W'(1))
    else $error("final size does not follow last write");
`endif

endmodule

// File: rtl/core/dns_name_label_encoder_unit.sv
// ----------------------------------------------------------------------------
// dns_name_label_encoder_unit : DNS question name encoder, top level
// Turns a dotted name, one character per word, into addressed byte writes
// in label form followed by type, class, status and new message size.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  in_ch    in   ch, end_of_name, msg_offset, query_type, query_class
//  out_ch   out  wr_offset, wr_byte, wr_valid, last, status, new_size
//
// One character is taken per cycle while the command queue has room.
// The back sequencer sends one word per cycle unless out_ch stalls: one for a
// character, up to seven for the final one, so the name tail sets the rate.
// Each character passes through the command queue and then the output register.
// Synchronous reset clears the name state, the queue and the output stage.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_unit #(
  parameter int MAX_LABEL = 63,
  parameter int MAX_NAME  = 255,
  parameter int MSG_LIMIT = 512,
  parameter int Q_DEPTH   = 4
) (
  input  logic        clk,
  input  logic        rst,
  dnsle_in_if.sink    in_ch,
  dnsle_out_if.source out_ch
);
  import dnsle_pkg::*;

  cmd_t front_cmd, head_cmd;
  logic push, pop, full, empty, take;

  assign in_ch.ready = !full;
  assign take        = in_ch.valid && !full;

  dnsle_front #(
    .MAX_LABEL (MAX_LABEL),
    .MAX_NAME  (MAX_NAME),
    .MSG_LIMIT (MSG_LIMIT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .ch          (in_ch.ch),
    .end_of_name (in_ch.end_of_name),
    .msg_offset  (in_ch.msg_offset),
    .query_type  (in_ch.query_type),
    .query_class (in_ch.query_class),
    .push        (push),
    .cmd         (front_cmd)
  );

  dnsle_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .full     (full),
    .empty    (empty)
  );

  dnsle_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head_cmd),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// File: bench/tb_dns_name_label_encoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dns_name_label_encoder_unit : self-checking bench for the name encoder
// Sends dotted names one character per word, predicts the byte writes and
// status words in a small scoreboard and checks every output word in order.
// Short hand-picked names and a long-name phase come first, then random names.
// The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_dns_name_label_encoder_unit;
  import dnsle_pkg::*;

  localparam int MAX_LABEL   = 63;
  localparam int MAX_NAME    = 255;
  localparam int MSG_LIMIT   = 512;
  localparam int ITEM_TARGET = 420;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    logic [OFF_W-1:0] wr_offset;
    logic [CH_W-1:0]  wr_byte;
    logic             wr_valid;
    logic             last;
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] new_size;
  } write_word_t;

  // Scoreboard: encodes each accepted character and queues the words it causes
  class name_encode_board;
    write_word_t pending_words[$];
    int          errors;
    int          words_checked;
    int          outcome_seen[5];
    // name encoding state
    int          msg_base;
    int          cursor;
    int          label_at;
    int          run_len;
    status_t     first_err;
    bit          mid_name;

    function new();
      errors = 0;
      words_checked = 0;
      foreach (outcome_seen[i]) outcome_seen[i] = 0;
      msg_base = 0;
      cursor = 1;
      label_at = 0;
      run_len = 0;
      first_err = ST_OK;
      mid_name = 1'b0;
    endfunction

    function void push_word(int off, int val, bit wv, bit lst, status_t st, int size);
      write_word_t w;
      w.wr_offset = off[OFF_W-1:0];
      w.wr_byte   = val[CH_W-1:0];
      w.wr_valid  = wv;
      w.last      = lst;
      w.status    = st;
      w.new_size  = size[OFF_W-1:0];
      pending_words.push_back(w);
    endfunction

    function void note_char(logic [7:0] ch, logic eon, logic [8:0] moff,
                            logic [15:0] qtype, logic [15:0] qclass);
      int tail;
      // first character latches where the question starts
      if (!mid_name) begin
        msg_base  = moff;
        cursor    = 1;
        label_at  = 0;
        run_len   = 0;
        first_err = ST_OK;
        mid_name  = 1'b1;
      end
      // character checks, limit first
      if (first_err == ST_OK) begin
        if (msg_base + cursor >= MSG_LIMIT) begin
          first_err = ST_LIMIT;
        end else if (cursor > MAX_NAME) begin
          first_err = ST_NAME_LONG;
        end else if (ch != DOT_CHAR) begin
          if (run_len < 255) run_len++;
          push_word(msg_base + cursor, ch, 1'b1, 1'b0, ST_OK, 0);
          cursor++;
        end else if (run_len == 0) begin
          first_err = ST_EMPTY;
        end else if (run_len > MAX_LABEL) begin
          first_err = ST_LABEL_LONG;
        end else begin
          // label finished: length goes back to its start
          push_word(msg_base + label_at, run_len, 1'b1, 1'b0, ST_OK, 0);
          label_at = cursor;
          cursor++;
          run_len = 0;
        end
      end
      // end of name: last label, terminator, type and class
      if (eon) begin
        if (first_err == ST_OK) begin
          if (run_len == 0) first_err = ST_EMPTY;
          else if (run_len > MAX_LABEL) first_err = ST_LABEL_LONG;
        end
        if (first_err != ST_OK) begin
          push_word(0, 0, 1'b0, 1'b1, first_err, 0);
        end else begin
          tail = msg_base + cursor;
          push_word(msg_base + label_at, run_len, 1'b1, 1'b0, ST_OK, 0);
          push_word(tail,     0,             1'b1, 1'b0, ST_OK, 0);
          push_word(tail + 1, qtype[15:8],   1'b1, 1'b0, ST_OK, 0);
          push_word(tail + 2, qtype[7:0],    1'b1, 1'b0, ST_OK, 0);
          push_word(tail + 3, qclass[15:8],  1'b1, 1'b0, ST_OK, 0);
          push_word(tail + 4, qclass[7:0],   1'b1, 1'b1, ST_OK, tail + 5);
        end
        outcome_seen[int'(first_err)]++;
        mid_name  = 1'b0;
        cursor    = 1;
        label_at  = 0;
        run_len   = 0;
        first_err = ST_OK;
      end
    endfunction

    function void report_field(string field, int exp_val, int got_val);
      $display("%0t: mismatch on %s, expected 0x%0h, actual 0x%0h",
               $time, field, exp_val, got_val);
      errors++;
    endfunction

    function void check_word(write_word_t got);
      write_word_t exp_w;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      exp_w = pending_words.pop_front();
      words_checked++;
      if (got.wr_offset !== exp_w.wr_offset)
        report_field("wr_offset", exp_w.wr_offset, got.wr_offset);
      if (got.wr_byte !== exp_w.wr_byte)
        report_field("wr_byte", exp_w.wr_byte, got.wr_byte);
      if (got.wr_valid !== exp_w.wr_valid)
        report_field("wr_valid", exp_w.wr_valid, got.wr_valid);
      if (got.last !== exp_w.last)
        report_field("last", exp_w.last, got.last);
      if (got.status !== exp_w.status)
        report_field("status", exp_w.status, got.status);
      if (got.new_size !== exp_w.new_size)
        report_field("new_size", exp_w.new_size, got.new_size);
    endfunction
  endclass

  logic clk;
  logic rst;

  dnsle_in_if  in_bus();
  dnsle_out_if out_bus();

  dns_name_label_encoder_unit #(
    .MAX_LABEL(MAX_LABEL),
    .MAX_NAME (MAX_NAME),
    .MSG_LIMIT(MSG_LIMIT)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  name_encode_board board;
  logic [7:0]       name_buf[$];
  int               burst_left;
  int               names_sent;
  int               chars_sent;
  int               cycle_count;
  int               rx_mode;
  int               rx_left;
  int               rx_phase;

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding",
               cycle_count, board.pending_words.size());
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: checks accepted words, stalls on a changing pattern
  always @(posedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready)
        board.check_word({out_bus.wr_offset, out_bus.wr_byte, out_bus.wr_valid,
                          out_bus.last, out_bus.status, out_bus.new_size});
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(30, 150);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        0: begin
          out_bus.ready <= 1'b1;
        end
        1: begin
          out_bus.ready <= ($urandom_range(0, 9) < 6);
        end
        default: begin
          out_bus.ready <= ((rx_phase % 5) >= 2);
        end
      endcase
    end
  end

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    do c = 8'($urandom); while (c == DOT_CHAR);
    return c;
  endfunction

  function automatic void add_label(int n);
    repeat (n) name_buf.push_back(rand_letter());
  endfunction

  function automatic void load_text(string s);
    name_buf.delete();
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
  endfunction

  // one character word; the sender works in bursts with idle gaps between
  task automatic send_char(input logic [7:0] c, input logic eon, input logic [8:0] moff,
                           input logic [15:0] qtype, input logic [15:0] qclass);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_bus.valid       <= 1'b1;
    in_bus.ch          <= c;
    in_bus.end_of_name <= eon;
    in_bus.msg_offset  <= moff;
    in_bus.query_type  <= qtype;
    in_bus.query_class <= qclass;
    do @(posedge clk); while (!in_bus.ready);
    board.note_char(c, eon, moff, qtype, qclass);
    chars_sent++;
  endtask

  // whole name from name_buf; offset, type and class only matter where used
  task automatic send_name(input logic [8:0] moff, input logic [15:0] qtype,
                           input logic [15:0] qclass);
    for (int i = 0; i < name_buf.size(); i++) begin
      logic fin;
      fin = (i == name_buf.size() - 1);
      send_char(name_buf[i], fin,
                (i == 0) ? moff : 9'($urandom_range(0, 511)),
                fin ? qtype : 16'($urandom), fin ? qclass : 16'($urandom));
    end
    names_sent++;
  endtask

  // random name of one of several shapes
  task automatic send_random_name();
    int pick;
    int nlab;
    logic [8:0] moff;
    pick = $urandom_range(0, 99);
    name_buf.delete();
    moff = 9'($urandom_range(12, 300));
    if (pick < 60) begin
      // well formed
      nlab = $urandom_range(1, 4);
      for (int i = 0; i < nlab; i++) begin
        if (i > 0) name_buf.push_back(DOT_CHAR);
        add_label(($urandom_range(0, 19) == 0) ? $urandom_range(40, 63)
                                               : $urandom_range(1, 10));
      end
    end else if (pick < 68) begin
      // label around the length limit
      if ($urandom_range(0, 1)) begin
        add_label($urandom_range(1, 5));
        name_buf.push_back(DOT_CHAR);
      end
      add_label($urandom_range(MAX_LABEL - 1, MAX_LABEL + 2));
      if ($urandom_range(0, 1)) begin
        name_buf.push_back(DOT_CHAR);
        add_label($urandom_range(1, 5));
      end
    end else if (pick < 78) begin
      // near the message limit
      moff = 9'($urandom_range(480, 511));
      nlab = $urandom_range(1, 3);
      for (int i = 0; i < nlab; i++) begin
        if (i > 0) name_buf.push_back(DOT_CHAR);
        add_label($urandom_range(1, 8));
      end
    end else if (pick < 88) begin
      // broken dots: leading, trailing or doubled
      case ($urandom_range(0, 2))
        0: begin
          name_buf.push_back(DOT_CHAR);
          add_label($urandom_range(1, 6));
        end
        1: begin
          add_label($urandom_range(1, 6));
          name_buf.push_back(DOT_CHAR);
        end
        default: begin
          add_label($urandom_range(1, 6));
          name_buf.push_back(DOT_CHAR);
          name_buf.push_back(DOT_CHAR);
          add_label($urandom_range(1, 6));
        end
      endcase
    end else begin
      // noise, any offset
      moff = 9'($urandom_range(0, 511));
      repeat ($urandom_range(1, 10))
        name_buf.push_back(($urandom_range(0, 2) == 0) ? DOT_CHAR : 8'($urandom));
    end
    send_name(moff, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    board       = new();
    burst_left  = 0;
    names_sent  = 0;
    chars_sent  = 0;
    cycle_count = 0;
    rx_mode     = 0;
    rx_left     = 0;
    rx_phase    = 0;
    rst         = 1'b1;
    in_bus.valid       <= 1'b0;
    in_bus.ch          <= '0;
    in_bus.end_of_name <= 1'b0;
    in_bus.msg_offset  <= '0;
    in_bus.query_type  <= '0;
    in_bus.query_class <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // short hand-picked names
    load_text("a");     send_name(9'd12, 16'h0000, 16'h0000);
    load_text("w.ex");  send_name(9'd12, 16'hFFFF, 16'hFFFF);
    load_text(".");     send_name(9'd40, 16'h0001, 16'h0001);
    load_text("ab.");   send_name(9'd40, 16'h00FF, 16'hFF00);
    load_text("a..b");  send_name(9'd60, 16'h1234, 16'h5678);
    load_text(".a");    send_name(9'd60, 16'h0001, 16'h0001);
    name_buf = '{8'h00, 8'hFF};
    send_name(9'd0, 16'hA5A5, 16'h5A5A);            // offset below the header size
    load_text("xy");    send_name(9'd511, 16'h0001, 16'h0001);
    load_text("abcd");  send_name(9'd507, 16'hBEEF, 16'hCAFE); // tail runs past the limit
    load_text("abcd");  send_name(9'd508, 16'h0001, 16'h0001);

    // long name: four full labels and one more character, past the maximum
    name_buf.delete();
    for (int i = 0; i < 4; i++) begin
      if (i > 0) name_buf.push_back(DOT_CHAR);
      add_label(MAX_LABEL);
    end
    add_label(1);
    send_name(9'd12, 16'h0001, 16'h0001);

    // random names, labels around the length limit included
    while (chars_sent < ITEM_TARGET) send_random_name();

    in_bus.valid <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d names in %0d characters, checked %0d output words",
             names_sent, chars_sent, board.words_checked);
    $display("Outcomes: ok %0d, msg limit %0d, name long %0d, empty %0d, label long %0d",
             board.outcome_seen[0], board.outcome_seen[1], board.outcome_seen[2],
             board.outcome_seen[3], board.outcome_seen[4]);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: dns_name_label_encoder_unit.f
rtl/core/dnsle_pkg.sv
rtl/core/dnsle_if.sv
rtl/core/dnsle_front.sv
rtl/core/dnsle_queue.sv
rtl/core/dnsle_back.sv
rtl/core/dns_name_label_encoder_unit.sv
bench/tb_dns_name_label_encoder_unit.sv
